[sv/m3i_pkg.sv]
// shared constants, tables and types for the 3x3 matrix inverse core
package m3i_pkg;

    // default element format
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // element order: a b c d e f g h i = r0c0 .. r2c2
    // adjugate entry k = x[ADJ_X[k]] * x[ADJ_Y[k]] - x[ADJ_Z[k]] * x[ADJ_W[k]]
    localparam int ADJ_X [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int ADJ_Y [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int ADJ_Z [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int ADJ_W [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // cofactor expansion along row 0 uses adjugate column 0
    localparam int DET_ADJ [3] = '{0, 3, 6};

    // queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[sv/matrix3x3_inverse_core.sv]
// top level of the 3x3 matrix inverse core: front, queue and back
// throughput: one item per cycle while busy is low, set by the fully pipelined divide lanes
// each divide lane resolves one quotient bit per stage over ELEM_WIDTH+1 stages
// reset: synchronous active-low i_rst_n drops all items in flight; no clearing pass
// results are shown for one cycle only; the receiver cannot stall
module matrix3x3_inverse_core #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r0c0,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r0c1,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r0c2,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r1c0,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r1c1,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r1c2,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r2c0,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r2c1,
    input  logic signed [ELEM_WIDTH-1:0]  i_in_r2c2,
    output logic                          o_strobe,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r0c0,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r0c1,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r0c2,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r1c0,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r1c1,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r1c2,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r2c0,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r2c1,
    output logic signed [ELEM_WIDTH-1:0]  o_inv_r2c2,
    output logic signed [ELEM_WIDTH-1:0]  o_det_value,
    output logic                          o_is_singular,
    output logic                          o_overflowed
);
    localparam int EW  = ELEM_WIDTH;
    localparam int AW  = 2 * EW + 1;
    localparam int DW  = 3 * EW + 3;
    localparam int QW  = 9 * AW + DW;
    localparam int LAT = EW + 11;

    logic signed [EW-1:0] elem [9];
    logic                 accept;
    logic                 f_valid;
    logic signed [AW-1:0] f_adj [9];
    logic signed [DW-1:0] f_det;
    logic [QW-1:0]        q_in;
    logic [QW-1:0]        q_out;
    logic                 q_valid;
    m3i_pkg::t_qstat      q_stat;
    logic signed [AW-1:0] b_adj [9];
    logic signed [DW-1:0] b_det;
    logic signed [EW-1:0] b_inv [9];

    assign elem[0] = i_in_r0c0;
    assign elem[1] = i_in_r0c1;
    assign elem[2] = i_in_r0c2;
    assign elem[3] = i_in_r1c0;
    assign elem[4] = i_in_r1c1;
    assign elem[5] = i_in_r1c2;
    assign elem[6] = i_in_r2c0;
    assign elem[7] = i_in_r2c1;
    assign elem[8] = i_in_r2c2;

    // item accept
    assign busy   = q_stat.full;
    assign accept = start && !busy;

    m3i_front #(.EW(EW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_elem  (elem),
        .o_valid (f_valid),
        .o_adj   (f_adj),
        .o_det   (f_det)
    );

    // pack and unpack queue payload
    always_comb begin
        q_in[DW-1:0] = f_det;
        for (int k = 0; k < 9; k++) begin
            q_in[DW + k*AW +: AW] = f_adj[k];
        end
    end

    always_comb begin
        b_det = q_out[DW-1:0];
        for (int k = 0; k < 9; k++) begin
            b_adj[k] = q_out[DW + k*AW +: AW];
        end
    end

    m3i_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (q_in),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    m3i_back #(.EW(EW), .F(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_adj         (b_adj),
        .i_det         (b_det),
        .o_strobe      (o_strobe),
        .o_inv         (b_inv),
        .o_det_value   (o_det_value),
        .o_is_singular (o_is_singular),
        .o_overflowed  (o_overflowed)
    );

    assign o_inv_r0c0 = b_inv[0];
    assign o_inv_r0c1 = b_inv[1];
    assign o_inv_r0c2 = b_inv[2];
    assign o_inv_r1c0 = b_inv[3];
    assign o_inv_r1c1 = b_inv[4];
    assign o_inv_r1c2 = b_inv[5];
    assign o_inv_r2c0 = b_inv[6];
    assign o_inv_r2c1 = b_inv[7];
    assign o_inv_r2c2 = b_inv[8];

`ifndef SYNTHESIS
    // every accepted item strobes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_strobe)
        else $error("item result missing after pipeline latency");

    // singular result carries zero determinant and no overflow
    a_sing_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_singular) |-> (o_det_value == '0) && !o_overflowed)
        else $error("singular result with bad flags");

    // singular result carries zero diagonal and corner inverse entries
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_singular) |->
            (o_inv_r0c0 == '0) && (o_inv_r1c1 == '0) && (o_inv_r2c2 == '0)
            && (o_inv_r0c2 == '0) && (o_inv_r2c0 == '0))
        else $error("singular result with nonzero inverse");

    // the queue is never written while full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !f_valid)
        else $error("queue overrun");
`endif

endmodule

[sv/m3i_front.sv]
// front part: adjugate and determinant pipeline, six stages
module m3i_front #(
    parameter int EW = m3i_pkg::ELEM_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [EW-1:0]    i_elem [9],
    output logic                    o_valid,
    output logic signed [2*EW:0]    o_adj [9],
    output logic signed [3*EW+2:0]  o_det
);
    localparam int AW = 2 * EW + 1;
    localparam int DW = 3 * EW + 3;

    logic [5:0]              r_vld;
    logic signed [EW-1:0]    r_x [9];
    logic signed [2*EW-1:0]  r_pa [9];
    logic signed [2*EW-1:0]  r_pb [9];
    logic signed [EW-1:0]    r_r0a [3];
    logic signed [EW-1:0]    r_r0b [3];
    logic signed [AW-1:0]    r_adj3 [9];
    logic signed [AW-1:0]    r_adj4 [9];
    logic signed [AW-1:0]    r_adj5 [9];
    logic signed [AW-1:0]    r_adj6 [9];
    logic signed [2*EW:0]    r_plo [3];
    logic signed [2*EW:0]    r_phi [3];
    logic signed [DW-1:0]    r_prod [3];
    logic signed [DW-1:0]    r_det;

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        // capture
        r_x <= i_elem;
        // cross products
        for (int k = 0; k < 9; k++) begin
            r_pa[k] <= r_x[m3i_pkg::ADJ_X[k]] * r_x[m3i_pkg::ADJ_Y[k]];
            r_pb[k] <= r_x[m3i_pkg::ADJ_Z[k]] * r_x[m3i_pkg::ADJ_W[k]];
        end
        for (int j = 0; j < 3; j++) begin
            r_r0a[j] <= r_x[j];
            r_r0b[j] <= r_r0a[j];
        end
        // adjugate
        for (int k = 0; k < 9; k++) begin
            r_adj3[k] <= AW'(r_pa[k]) - AW'(r_pb[k]);
        end
        // determinant partial products, split low and high halves
        for (int j = 0; j < 3; j++) begin
            r_plo[j] <= r_r0b[j] * $signed({1'b0, r_adj3[m3i_pkg::DET_ADJ[j]][EW-1:0]});
            r_phi[j] <= r_r0b[j] * $signed(r_adj3[m3i_pkg::DET_ADJ[j]][AW-1:EW]);
        end
        r_adj4 <= r_adj3;
        // recombine halves
        for (int j = 0; j < 3; j++) begin
            r_prod[j] <= (DW'(r_phi[j]) <<< EW) + DW'(r_plo[j]);
        end
        r_adj5 <= r_adj4;
        // sum of cofactor terms
        r_det  <= r_prod[0] + r_prod[1] + r_prod[2];
        r_adj6 <= r_adj5;
    end

    assign o_valid = r_vld[5];
    assign o_adj   = r_adj6;
    assign o_det   = r_det;

endmodule

[sv/m3i_queue.sv]
// small item queue between front and back
module m3i_queue #(
    parameter int W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [W-1:0]     o_data,
    output m3i_pkg::t_qstat  o_stat
);
    localparam int D  = m3i_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;

    logic [W-1:0]  r_mem [D];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(D - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(D - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid      = (r_cnt != '0);
    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (PW+1)'(D));
    assign o_stat.empty = (r_cnt == '0);

endmodule

[sv/m3i_div.sv]
// one rounded, saturating divide lane: round(num * 2^(2F) / den), one quotient bit per stage
module m3i_div #(
    parameter int EW = m3i_pkg::ELEM_WIDTH,
    parameter int F  = m3i_pkg::FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic signed [2*EW:0]    i_num,
    input  logic signed [3*EW+2:0]  i_den,
    output logic signed [EW-1:0]    o_quot,
    output logic                    o_ovf
);
    localparam int AW = 2 * EW + 1;
    localparam int DW = 3 * EW + 3;
    localparam int NW = AW - 1 + 2 * F;
    localparam int QB = EW + 1;
    localparam int CW = (NW > DW - 1 + QB) ? NW : DW - 1 + QB;
    localparam logic [QB:0]   LIM  = {{(QB + 1 - EW){1'b0}}, 1'b1, {(EW - 1){1'b0}}};
    localparam logic [EW-1:0] MAXV = {1'b0, {(EW - 1){1'b1}}};
    localparam logic [EW-1:0] MINV = {1'b1, {(EW - 1){1'b0}}};

    logic [AW-1:0]  num_abs;
    logic [DW-1:0]  den_abs;
    logic [CW-1:0]  r_n;
    logic [CW-1:0]  r_d;
    logic           r_neg;
    logic [CW-1:0]  r_rem [QB+1];
    logic [CW-1:0]  r_dd  [QB+1];
    logic [QB-1:0]  r_q   [QB+1];
    logic           r_ng  [QB+1];
    logic           r_bg  [QB+1];
    logic [CW:0]    rem2;
    logic           rnd;
    logic [QB:0]    qr;
    logic [QB:0]    qneg;
    logic [EW-1:0]  res;
    logic           res_ovf;

    // magnitudes and result sign
    assign num_abs = i_num[AW-1] ? AW'(-i_num) : AW'(i_num);
    assign den_abs = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);

    always_ff @(posedge i_clk) begin
        r_n   <= CW'(num_abs[AW-2:0]) << (2 * F);
        r_d   <= CW'(den_abs[DW-2:0]);
        r_neg <= i_num[AW-1] ^ i_den[DW-1];
    end

    // first step inputs; flag a quotient too large for the lane, to saturate later
    always_ff @(posedge i_clk) begin
        r_rem[0] <= r_n;
        r_dd[0]  <= r_d;
        r_q[0]   <= '0;
        r_ng[0]  <= r_neg;
        r_bg[0]  <= (r_n >= (r_d << QB));
    end

    // restoring steps, most significant quotient bit first
    for (genvar s = 0; s < QB; s++) begin : g_step
        localparam int K = QB - 1 - s;
        logic [CW-1:0] sub;
        assign sub = r_dd[s] << K;
        always_ff @(posedge i_clk) begin
            if (r_rem[s] >= sub) begin
                r_rem[s+1] <= r_rem[s] - sub;
                r_q[s+1]   <= r_q[s] | (QB'(1) << K);
            end else begin
                r_rem[s+1] <= r_rem[s];
                r_q[s+1]   <= r_q[s];
            end
            r_dd[s+1] <= r_dd[s];
            r_ng[s+1] <= r_ng[s];
            r_bg[s+1] <= r_bg[s];
        end
    end

    // round half away from zero, apply sign, saturate
    assign rem2 = {r_rem[QB], 1'b0};
    assign rnd  = (rem2 >= {1'b0, r_dd[QB]}) && (r_dd[QB] != '0);
    assign qr   = {1'b0, r_q[QB]} + (QB+1)'(rnd);
    assign qneg = ~qr + 1'b1;

    always_comb begin
        res     = qr[EW-1:0];
        res_ovf = 1'b0;
        if (r_ng[QB]) begin
            if (r_bg[QB] || (qr > LIM)) begin
                res     = MINV;
                res_ovf = 1'b1;
            end else begin
                res = qneg[EW-1:0];
            end
        end else if (r_bg[QB] || (qr >= LIM)) begin
            res     = MAXV;
            res_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_quot <= res;
        o_ovf  <= res_ovf;
    end

endmodule

[sv/m3i_back.sv]
// back part: nine divide lanes, determinant rounding and result flags
module m3i_back #(
    parameter int EW = m3i_pkg::ELEM_WIDTH,
    parameter int F  = m3i_pkg::FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [2*EW:0]    i_adj [9],
    input  logic signed [3*EW+2:0]  i_det,
    output logic                    o_strobe,
    output logic signed [EW-1:0]    o_inv [9],
    output logic signed [EW-1:0]    o_det_value,
    output logic                    o_is_singular,
    output logic                    o_overflowed
);
    localparam int DW = 3 * EW + 3;
    localparam int L  = EW + 4;
    localparam logic [DW-1:0] DLIM = DW'(1) << (EW - 1);
    localparam logic [EW-1:0] MAXV = {1'b0, {(EW - 1){1'b1}}};
    localparam logic [EW-1:0] MINV = {1'b1, {(EW - 1){1'b0}}};

    logic signed [EW-1:0] lane_q [9];
    logic [8:0]           lane_ovf;
    logic [DW-1:0]        det_abs;
    logic [DW-1:0]        det_rnd;
    logic [DW-1:0]        det_rneg;
    logic [EW-1:0]        dv;
    logic                 dv_ovf;
    logic [L-1:0]         r_vld;
    logic [EW-1:0]        r_dv  [L];
    logic                 r_dov [L];
    logic                 r_sg  [L];

    // divide lanes
    for (genvar k = 0; k < 9; k++) begin : g_lane
        m3i_div #(.EW(EW), .F(F)) u_div (
            .i_clk  (i_clk),
            .i_num  (i_adj[k]),
            .i_den  (i_det),
            .o_quot (lane_q[k]),
            .o_ovf  (lane_ovf[k])
        );
    end

    // determinant scaled back to the element format
    assign det_abs  = i_det[DW-1] ? DW'(-i_det) : DW'(i_det);
    assign det_rnd  = (det_abs + (DW'(1) << (2 * F - 1))) >> (2 * F);
    assign det_rneg = ~det_rnd + 1'b1;

    always_comb begin
        dv     = det_rnd[EW-1:0];
        dv_ovf = 1'b0;
        if (i_det[DW-1]) begin
            if (det_rnd > DLIM) begin
                dv     = MINV;
                dv_ovf = 1'b1;
            end else begin
                dv = det_rneg[EW-1:0];
            end
        end else if (det_rnd >= DLIM) begin
            dv     = MAXV;
            dv_ovf = 1'b1;
        end
    end

    // valid line matched to lane latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // side values matched to lane latency
    always_ff @(posedge i_clk) begin
        r_dv[0]  <= dv;
        r_dov[0] <= dv_ovf;
        r_sg[0]  <= (i_det == '0);
        for (int s = 1; s < L; s++) begin
            r_dv[s]  <= r_dv[s-1];
            r_dov[s] <= r_dov[s-1];
            r_sg[s]  <= r_sg[s-1];
        end
    end

    // singular matrix: zero inverse, no inverse overflow
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_inv[k] = r_sg[L-1] ? '0 : lane_q[k];
        end
    end

    assign o_strobe      = r_vld[L-1];
    assign o_det_value   = r_dv[L-1];
    assign o_is_singular = r_sg[L-1];
    assign o_overflowed  = r_dov[L-1] || (!r_sg[L-1] && (lane_ovf != '0));

endmodule

[sim/testbench.sv]
// self-checking testbench for the 3x3 matrix inverse core
module testbench;

    localparam int EW = m3i_pkg::ELEM_WIDTH;
    localparam int FB = m3i_pkg::FRAC_BITS;
    localparam int WW = 256;
    localparam int LATENCY = EW + 11;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 800;

    typedef logic signed [EW-1:0] t_elem;
    typedef logic signed [WW-1:0] t_wide;

    // one expected or observed result
    typedef struct {
        t_elem inv [9];
        t_elem det;
        logic  singular;
        logic  ovf;
    } t_inverse;

    // scoreboard: computes expected inverses and checks observed ones
    class inverse_scoreboard;
        t_inverse pending[$];
        int       mismatches;

        function new();
            pending.delete();
            mismatches = 0;
        endfunction

        // rounded signed divide, ties away from zero
        static function t_wide round_div(t_wide num, t_wide den);
            t_wide n;
            t_wide d;
            t_wide q;
            t_wide r;
            logic  neg;
            neg = num[WW-1] ^ den[WW-1];
            n = num[WW-1] ? -num : num;
            d = den[WW-1] ? -den : den;
            q = n / d;
            r = n % d;
            if ((r << 1) >= d) q = q + 1;
            return neg ? -q : q;
        endfunction

        // clamp to the element range
        static function t_elem clamp(t_wide v, ref logic ovf);
            t_wide top;
            t_wide bot;
            top = (t_wide'(1) <<< (EW - 1)) - 1;
            bot = -(t_wide'(1) <<< (EW - 1));
            if (v > top) begin
                ovf = 1'b1;
                return top[EW-1:0];
            end
            if (v < bot) begin
                ovf = 1'b1;
                return bot[EW-1:0];
            end
            return v[EW-1:0];
        endfunction

        function void note_item(t_elem m [9]);
            t_wide    x [9];
            t_wide    adj [9];
            t_wide    det;
            t_wide    scale;
            t_inverse exp_r;
            logic     ovf;
            for (int k = 0; k < 9; k++) x[k] = t_wide'(m[k]);
            adj[0] = x[4] * x[8] - x[5] * x[7];
            adj[1] = x[2] * x[7] - x[1] * x[8];
            adj[2] = x[1] * x[5] - x[2] * x[4];
            adj[3] = x[5] * x[6] - x[3] * x[8];
            adj[4] = x[0] * x[8] - x[2] * x[6];
            adj[5] = x[2] * x[3] - x[0] * x[5];
            adj[6] = x[3] * x[7] - x[4] * x[6];
            adj[7] = x[1] * x[6] - x[0] * x[7];
            adj[8] = x[0] * x[4] - x[1] * x[3];
            det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
            scale = t_wide'(1) <<< (2 * FB);
            ovf = 1'b0;
            exp_r.det = clamp(round_div(det, scale), ovf);
            exp_r.singular = (det == 0);
            for (int k = 0; k < 9; k++)
                exp_r.inv[k] = (det == 0) ? '0 : clamp(round_div(adj[k] * scale, det), ovf);
            exp_r.ovf = ovf;
            pending.push_back(exp_r);
        endfunction

        task check_result(t_inverse got);
            t_inverse exp_r;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending");
                return;
            end
            exp_r = pending.pop_front();
            for (int k = 0; k < 9; k++)
                if (got.inv[k] !== exp_r.inv[k])
                    report_mismatch($sformatf("inv[%0d] got %h exp %h",
                                              k, got.inv[k], exp_r.inv[k]));
            if (got.det !== exp_r.det)
                report_mismatch($sformatf("det got %h exp %h", got.det, exp_r.det));
            if (got.singular !== exp_r.singular)
                report_mismatch($sformatf("singular got %b exp %b",
                                          got.singular, exp_r.singular));
            if (got.ovf !== exp_r.ovf)
                report_mismatch($sformatf("overflow got %b exp %b", got.ovf, exp_r.ovf));
        endtask

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_elem elem [9];
    logic  o_strobe;
    t_elem o_inv [9];
    t_elem o_det_value;
    logic  o_is_singular;
    logic  o_overflowed;

    inverse_scoreboard sb;
    int idle_cycles;
    int accepted;

    matrix3x3_inverse_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in_r0c0(elem[0]), .i_in_r0c1(elem[1]), .i_in_r0c2(elem[2]),
        .i_in_r1c0(elem[3]), .i_in_r1c1(elem[4]), .i_in_r1c2(elem[5]),
        .i_in_r2c0(elem[6]), .i_in_r2c1(elem[7]), .i_in_r2c2(elem[8]),
        .o_strobe(o_strobe),
        .o_inv_r0c0(o_inv[0]), .o_inv_r0c1(o_inv[1]), .o_inv_r0c2(o_inv[2]),
        .o_inv_r1c0(o_inv[3]), .o_inv_r1c1(o_inv[4]), .o_inv_r1c2(o_inv[5]),
        .o_inv_r2c0(o_inv[6]), .o_inv_r2c1(o_inv[7]), .o_inv_r2c2(o_inv[8]),
        .o_det_value(o_det_value), .o_is_singular(o_is_singular),
        .o_overflowed(o_overflowed)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result sampling and watchdog
    always @(posedge i_clk) begin
        t_inverse got;
        if (i_rst_n && o_strobe) begin
            for (int k = 0; k < 9; k++) got.inv[k] = o_inv[k];
            got.det = o_det_value;
            got.singular = o_is_singular;
            got.ovf = o_overflowed;
            sb.check_result(got);
        end
        if ((i_rst_n && o_strobe) || (start && !busy) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // random element, biased toward small and extreme values
    function automatic t_elem rand_elem();
        case ($urandom_range(0, 5))
            0: return t_elem'($urandom());
            1: return t_elem'(int'($urandom_range(0, 8)) - 4) <<< FB;
            2: return t_elem'(int'($urandom_range(0, 2000)) - 1000) <<< 8;
            3: return $urandom_range(0, 1) ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
            4: return t_elem'(int'($urandom_range(0, 6)) - 3);
            default: return t_elem'(int'($urandom_range(0, 65535)) - 32768) <<< 4;
        endcase
    endfunction

    // wait a random gap, present one matrix and wait until it is taken
    task automatic send_matrix(t_elem m [9]);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        for (int k = 0; k < 9; k++) elem[k] = m[k];
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(m);
        accepted++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic send_diag(t_elem a, t_elem b, t_elem c);
        t_elem m [9];
        foreach (m[k]) m[k] = '0;
        m[0] = a; m[4] = b; m[8] = c;
        send_matrix(m);
    endtask

    initial begin
        t_elem m [9];
        t_elem one;
        t_elem emax;
        t_elem emin;
        one = t_elem'(1) <<< FB;
        emax = {1'b0, {(EW-1){1'b1}}};
        emin = {1'b1, {(EW-1){1'b0}}};
        sb = new();
        idle_cycles = 0;
        accepted = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        foreach (elem[k]) elem[k] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: identity, zero, scaled, extremes, tiny and singular
        send_diag(one, one, one);
        send_diag('0, '0, '0);
        send_diag(one <<< 1, -one, one >>> 1);
        send_diag(emax, emax, emax);
        send_diag(emin, emin, emin);
        send_diag(emin, emax, emin);
        send_diag(t_elem'(1), t_elem'(1), t_elem'(1));
        send_diag(t_elem'(256), t_elem'(256), t_elem'(256));
        send_diag(-one, -one, -one);
        foreach (m[k]) m[k] = emax;
        send_matrix(m);
        foreach (m[k]) m[k] = emin;
        send_matrix(m);
        foreach (m[k]) m[k] = t_elem'(k + 1) <<< FB;
        send_matrix(m);
        foreach (m[k]) m[k] = (k % 2) ? emin : emax;
        send_matrix(m);
        foreach (m[k]) m[k] = '1;
        send_matrix(m);
        // permutation matrix
        foreach (m[k]) m[k] = '0;
        m[1] = one; m[5] = one; m[6] = one;
        send_matrix(m);
        // rotation-like
        m[0] = 46341; m[1] = -46341; m[2] = 0;
        m[3] = 46341; m[4] = 46341;  m[5] = 0;
        m[6] = 0;     m[7] = 0;      m[8] = one;
        send_matrix(m);

        // random
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            foreach (m[k]) m[k] = rand_elem();
            case ($urandom_range(0, 7))
                // singular by repeated row
                0: for (int k = 0; k < 3; k++) m[6 + k] = m[k];
                // singular by scaled column
                1: for (int r = 0; r < 3; r++) m[3 * r + 2] = m[3 * r] <<< 1;
                // well-conditioned near-diagonal
                2: begin
                    foreach (m[k]) m[k] = t_elem'(int'($urandom_range(0, 4096)) - 2048);
                    m[0] = one + m[0]; m[4] = one - m[4]; m[8] = one + m[8];
                end
                default: ;
            endcase
            send_matrix(m);
        end

        // drain
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.mismatches == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
